FILE: rtl/core/grammar_text_lexer_macros.svh
// assertion macros shared by the grammar text lexer rtl
`ifndef GRAMMAR_TEXT_LEXER_MACROS_SVH
`define GRAMMAR_TEXT_LEXER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is held
`define GTL_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gtl assertion failed");

// next-cycle implication, disabled while reset is held
`define GTL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gtl assertion failed");

`else

`define GTL_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define GTL_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/gtl_pkg.sv
// shared types and constants of the grammar text lexer
`default_nettype none

package gtl_pkg;

    // internal counter widths
    localparam int LENGTH_BITS = 16;
    localparam int OFFSET_BITS = 32;

    // result field widths
    localparam int KIND_BITS       = 4;
    localparam int OUT_OFFSET_BITS = 32;
    localparam int OUT_LENGTH_BITS = 16;
    localparam int OUT_FIELD_BITS  = KIND_BITS + OUT_OFFSET_BITS + OUT_LENGTH_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_BITS   = 8;

    // queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONTERM = 4'd0,
        KIND_NAME    = 4'd1,
        KIND_BLANKS  = 4'd2,
        KIND_OPEN    = 4'd3,
        KIND_CLOSE   = 4'd4,
        KIND_DEFINE  = 4'd5,
        KIND_OR      = 4'd6,
        KIND_PADDING = 4'd7,
        KIND_NEWLINE = 4'd8,
        KIND_INVALID = 4'd9,
        KIND_END     = 4'd10
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
    } lexeme_t;

    // one queue entry carries the one or two lexemes of a byte
    typedef struct packed {
        logic    two;
        lexeme_t first;
        lexeme_t second;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/gtl_front.sv
// front part: byte classification and lexeme scanning state machine
`default_nettype none

module gtl_front
    import gtl_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [IN_TDATA_BITS-1:0] s_tdata,    // [7:0] text_byte
    input  wire q_status_t                q_status,
    output logic                          q_push,
    output q_entry_t                      q_entry
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NAME,
        MODE_NT_NAME,
        MODE_BLANK_TAIL,
        MODE_NEWLINES,
        MODE_PADDING
    } mode_t;

    typedef struct packed {
        logic  emit;
        kind_t emit_kind;
        logic  emit_one;
        logic  open;
        mode_t open_mode;
        kind_t open_kind;
    } fresh_t;

    mode_t                  mode_reg, mode_next;
    logic                   at_start_reg, at_start_next;
    kind_t                  kind_reg, kind_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    logic [7:0]             b;
    logic                   accept;
    logic [LENGTH_BITS-1:0] grown;
    fresh_t                 fr;
    logic                   do_fresh;
    logic                   do_close;
    kind_t                  close_kind;
    lexeme_t                fresh_lex;
    lexeme_t                closed_lex;

    // byte classes
    function automatic logic is_name(input logic [7:0] v);
        return (v >= 8'h21 && v <= 8'h39) || (v >= 8'h3B && v <= 8'h7A) || v == 8'h7E;
    endfunction

    function automatic logic is_blank(input logic [7:0] v);
        return v == 8'h20 || v == 8'h09;
    endfunction

    function automatic logic is_newline(input logic [7:0] v);
        return v == 8'h0A || v == 8'h0D;
    endfunction

    // action for a byte that arrives with no lexeme open
    function automatic fresh_t fresh_of(input logic [7:0] v, input logic at_start);
        fresh_t f;
        f = '{emit: 1'b0, emit_kind: KIND_INVALID, emit_one: 1'b1,
              open: 1'b0, open_mode: MODE_IDLE, open_kind: KIND_NAME};
        priority if (v == 8'h00) begin
            f.emit      = 1'b1;
            f.emit_kind = KIND_END;
            f.emit_one  = 1'b0;
        end else if (is_name(v)) begin
            f.open      = 1'b1;
            f.open_mode = at_start ? MODE_NT_NAME : MODE_NAME;
            f.open_kind = at_start ? KIND_NONTERM : KIND_NAME;
        end else if (is_blank(v)) begin
            f.open      = 1'b1;
            f.open_mode = MODE_BLANK_TAIL;
            f.open_kind = KIND_BLANKS;
        end else if (v == 8'h7B) begin
            f.emit      = 1'b1;
            f.emit_kind = KIND_OPEN;
        end else if (v == 8'h7D) begin
            f.emit      = 1'b1;
            f.emit_kind = KIND_CLOSE;
        end else if (v == 8'h3A) begin
            f.open      = 1'b1;
            f.open_mode = MODE_BLANK_TAIL;
            f.open_kind = KIND_DEFINE;
        end else if (v == 8'h7C) begin
            f.open      = 1'b1;
            f.open_mode = MODE_BLANK_TAIL;
            f.open_kind = KIND_OR;
        end else if (is_newline(v)) begin
            f.open      = 1'b1;
            f.open_mode = MODE_NEWLINES;
            f.open_kind = KIND_NEWLINE;
        end else begin
            f.emit      = 1'b1;
            f.emit_kind = KIND_INVALID;
        end
        return f;
    endfunction

    assign b        = s_tdata;
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign grown    = (len_reg == {LENGTH_BITS{1'b1}}) ? len_reg
                                                       : len_reg + LENGTH_BITS'(1);
    assign fr       = fresh_of(b, at_start_reg);

    // per-mode decision: extend, close, or hand the byte to the fresh path
    always_comb begin
        mode_next  = mode_reg;
        kind_next  = kind_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        do_fresh   = 1'b0;
        do_close   = 1'b0;
        close_kind = kind_reg;
        unique case (mode_reg)
            MODE_NAME: begin
                if (is_name(b)) begin
                    len_next = grown;
                end else begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_NT_NAME: begin
                if (is_name(b)) begin
                    len_next = grown;
                end else if (b == 8'h00) begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end else begin
                    len_next  = grown;
                    mode_next = MODE_BLANK_TAIL;
                end
            end
            MODE_BLANK_TAIL: begin
                if (is_blank(b)) begin
                    len_next = grown;
                end else begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_NEWLINES: begin
                if (is_newline(b)) begin
                    len_next = grown;
                end else if (b == 8'h00) begin
                    do_fresh = 1'b1;
                end else if (is_name(b)) begin
                    len_next  = grown;
                    kind_next = KIND_NONTERM;
                    mode_next = MODE_NT_NAME;
                end else if (is_blank(b)) begin
                    len_next  = grown;
                    kind_next = KIND_PADDING;
                    mode_next = MODE_PADDING;
                end else begin
                    close_kind = KIND_NEWLINE;
                    do_close   = 1'b1;
                    do_fresh   = 1'b1;
                end
            end
            MODE_PADDING: begin
                if (is_newline(b)) begin
                    len_next  = grown;
                    kind_next = KIND_NEWLINE;
                    mode_next = MODE_NEWLINES;
                end else if (is_blank(b)) begin
                    len_next = grown;
                end else begin
                    do_close = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_IDLE: begin
                do_fresh = 1'b1;
            end
            default: begin
                do_fresh = 1'b1;
            end
        endcase

        // fresh path opens a lexeme or leaves the scanner idle
        if (do_fresh) begin
            mode_next = fr.open ? fr.open_mode : MODE_IDLE;
            if (fr.open) begin
                kind_next = fr.open_kind;
                off_next  = pos_reg;
                len_next  = LENGTH_BITS'(1);
            end
        end

        // end of text rearms the start rule and the offset counter
        if (b == 8'h00) begin
            mode_next     = MODE_IDLE;
            at_start_next = 1'b1;
            pos_next      = '0;
        end else begin
            at_start_next = 1'b0;
            pos_next      = pos_reg + OFFSET_BITS'(1);
        end
    end

    // lexemes produced by this byte
    always_comb begin
        closed_lex = '{kind: close_kind, offset: off_reg, length: len_reg};
        fresh_lex  = '{kind: fr.emit_kind, offset: pos_reg,
                       length: fr.emit_one ? LENGTH_BITS'(1) : LENGTH_BITS'(0)};
        q_entry.two    = do_close && do_fresh && fr.emit;
        q_entry.first  = do_close ? closed_lex : fresh_lex;
        q_entry.second = fresh_lex;
        q_push         = accept && (do_close || (do_fresh && fr.emit));
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            at_start_reg <= 1'b1;
            kind_reg     <= KIND_NONTERM;
            off_reg      <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            at_start_reg <= at_start_next;
            kind_reg     <= kind_next;
            off_reg      <= off_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/gtl_queue.sv
// short queue of lexeme entries between front and back
`default_nettype none
`include "grammar_text_lexer_macros.svh"

module gtl_queue
    import gtl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      head_entry,
    output q_status_t     status
);

    q_entry_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign status.full  = (count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_entry   = slot_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_BITS + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_BITS + 1)'(1);
            end
        end
    end

    `GTL_ASSERT_IMPLY(a_no_push_full, aclk, aresetn, status.full, !push)
    `GTL_ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, status.empty, !pop)
    `GTL_ASSERT_NEXT(a_push_fills, aclk, aresetn, push && !pop, !status.empty)

endmodule

`default_nettype wire

FILE: rtl/core/gtl_back.sv
// back part: splits queue entries into single lexemes on the output register
`default_nettype none
`include "grammar_text_lexer_macros.svh"

module gtl_back
    import gtl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire q_status_t            q_status,
    input  wire q_entry_t             q_head,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata   // [3:0] lexeme_kind, [35:4] lexeme_offset,
                                                // [51:36] lexeme_length
);

    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;
    logic                      pend_valid_reg;
    lexeme_t                   pend_reg;
    logic                      out_free;

    // fit internal widths to the result fields
    function automatic logic [OUT_TDATA_BITS-1:0] pack_lexeme(input lexeme_t lx);
        logic [OFFSET_BITS+OUT_OFFSET_BITS-1:0] off_ext;
        logic [LENGTH_BITS+OUT_LENGTH_BITS-1:0] len_ext;
        off_ext = {{OUT_OFFSET_BITS{1'b0}}, lx.offset};
        len_ext = {{OUT_LENGTH_BITS{1'b0}}, lx.length};
        return OUT_TDATA_BITS'({len_ext[OUT_LENGTH_BITS-1:0],
                                off_ext[OUT_OFFSET_BITS-1:0], lx.kind});
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = out_free && !pend_valid_reg && !q_status.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // output register, pending second lexeme first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (pend_valid_reg) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (!q_status.empty) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= q_head.two;
            end else begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_valid_reg) begin
                out_data_reg <= pack_lexeme(pend_reg);
            end else if (!q_status.empty) begin
                out_data_reg <= pack_lexeme(q_head.first);
                pend_reg     <= q_head.second;
            end
        end
    end

    `GTL_ASSERT_IMPLY(a_pend_has_out, aclk, aresetn, pend_valid_reg, out_valid_reg)
    `GTL_ASSERT_IMPLY(a_pop_no_pend, aclk, aresetn, q_pop, !pend_valid_reg && out_free)

endmodule

`default_nettype wire

FILE: rtl/core/grammar_text_lexer.sv
// Grammar text lexer: one byte in per cycle while the queue has room, one lexeme out per cycle.
// The closing byte queues a lexeme; it then moves to the output register that drives m_tdata;
// a byte that closes a lexeme and emits a one-byte or end lexeme yields the second after the first.
// Throughput: one byte per cycle while results leave at one per cycle; the four-entry
// front-to-back queue and the output register set how long a stalled output can be absorbed.
// Reset (aresetn low, synchronous): scanner idle at text start, offset zero, queue and output empty.
`default_nettype none

module grammar_text_lexer
    import gtl_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] text_byte
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0]      m_tdata    // [3:0] lexeme_kind, [35:4] lexeme_offset,
                                                      // [51:36] lexeme_length
);

    q_status_t q_status;
    logic      q_push;
    logic      q_pop;
    q_entry_t  q_entry;
    q_entry_t  q_head;

    // byte scanner
    gtl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // decoupling queue
    gtl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head_entry (q_head),
        .status     (q_status)
    );

    // result serializer
    gtl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
